[src/sudc_pkg.sv]
package sudc_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_REPLY = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_GOOD    = 2'd1;
	localparam logic [1:0] ST_HEADER  = 2'd2;
	localparam logic [1:0] ST_CRC     = 2'd3;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [7:0] SYNC_BYTE   = 8'h05;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] MASTER_ADDR = 8'hFF;

	localparam logic [2:0] REPLY_LAST = 3'd7;
	localparam logic [2:0] WRITE_LAST = 3'd7;
	localparam logic [2:0] READ_LAST  = 3'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [6:0]  register_index;
		logic [31:0] write_value;
		logic [7:0]  reply_byte;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [1:0]  reply_status;
		logic [31:0] read_data;
	} out_item_t;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic        is_reply;
		logic        is_write;
		logic [1:0]  node;
		logic [6:0]  reg_idx;
		logic [31:0] value;
		logic [1:0]  status;
		logic [31:0] data;
	} job_t;

	// crc-8, poly 0x07, data bits taken lsb first
	function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		logic       mix;
		c = crc;
		for (int j = 0; j < 8; j++) begin
			mix = c[7] ^ b[j];
			c = {c[6:0], 1'b0};
			if (mix) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

[src/sudc_fifo.sv]
module sudc_fifo #(
	parameter int DEPTH = 2,
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wr_data,
	output logic full,
	input  logic pop,
	output T     rd_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/sudc_front.sv]
module sudc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_data,
	input  logic              push,
	input  sudc_pkg::in_item_t in_item,
	input  logic              job_full,
	output logic              job_push,
	output sudc_pkg::job_t    job
);

	logic [1:0]  node_q;
	logic [6:0]  expected_q;
	logic [2:0]  count_q;
	logic [7:0]  crc_q;
	logic        hdr_err_q;
	logic [31:0] shift_q;

	logic        accept;
	logic        is_reply;
	logic        hdr_bad;
	logic [1:0]  status;

	assign accept   = push && !job_full;
	assign is_reply = (in_item.operation == sudc_pkg::OP_REPLY);
	assign job_push = accept && (in_item.operation != sudc_pkg::OP_NONE);

	always_comb begin
		hdr_bad = 1'b0;
		case (count_q)
			3'd0: hdr_bad = (in_item.reply_byte != sudc_pkg::SYNC_BYTE);
			3'd1: hdr_bad = (in_item.reply_byte != sudc_pkg::MASTER_ADDR);
			3'd2: hdr_bad = (in_item.reply_byte[6:0] != expected_q);
			default: hdr_bad = 1'b0;
		endcase
	end

	always_comb begin
		status = sudc_pkg::ST_PENDING;
		if (count_q == sudc_pkg::REPLY_LAST) begin
			if (hdr_err_q) begin
				status = sudc_pkg::ST_HEADER;
			end else if (crc_q != in_item.reply_byte) begin
				status = sudc_pkg::ST_CRC;
			end else begin
				status = sudc_pkg::ST_GOOD;
			end
		end
	end

	always_comb begin
		job.is_reply = is_reply;
		job.is_write = (in_item.operation == sudc_pkg::OP_WRITE);
		job.node     = node_q;
		job.reg_idx  = in_item.register_index;
		job.value    = in_item.write_value;
		job.status   = is_reply ? status : sudc_pkg::ST_PENDING;
		job.data     = (is_reply && status == sudc_pkg::ST_GOOD) ? shift_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q     <= '0;
			expected_q <= '0;
			count_q    <= '0;
			crc_q      <= '0;
			hdr_err_q  <= 1'b0;
			shift_q    <= '0;
		end else begin
			if (cfg_valid) begin
				node_q <= cfg_data;
			end
			if (accept) begin
				case (in_item.operation)
					sudc_pkg::OP_READ: begin
						expected_q <= in_item.register_index;
						count_q    <= '0;
						crc_q      <= '0;
						hdr_err_q  <= 1'b0;
						shift_q    <= '0;
					end
					sudc_pkg::OP_REPLY: begin
						if (count_q == sudc_pkg::REPLY_LAST) begin
							count_q   <= '0;
							crc_q     <= '0;
							hdr_err_q <= 1'b0;
							shift_q   <= '0;
						end else begin
							if (hdr_bad) begin
								hdr_err_q <= 1'b1;
							end
							if (count_q >= 3'd3) begin
								shift_q <= {shift_q[23:0], in_item.reply_byte};
							end
							crc_q   <= sudc_pkg::crc_fold(crc_q, in_item.reply_byte);
							count_q <= count_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[src/sudc_back.sv]
module sudc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_empty,
	input  sudc_pkg::job_t     job,
	output logic               job_pop,
	input  logic               out_full,
	output logic               out_push,
	output sudc_pkg::out_item_t out_item
);

	logic [2:0] idx_q;
	logic [7:0] crc_q;
	logic [2:0] last_idx;
	logic [7:0] byte_val;
	logic       at_end;
	logic       step;

	assign step     = !job_empty && !out_full;
	assign last_idx = job.is_write ? sudc_pkg::WRITE_LAST : sudc_pkg::READ_LAST;
	assign at_end   = (idx_q == last_idx);
	assign out_push = step;
	assign job_pop  = step && (job.is_reply || at_end);

	always_comb begin
		case (idx_q)
			3'd0: byte_val = sudc_pkg::SYNC_BYTE;
			3'd1: byte_val = {6'd0, job.node};
			3'd2: byte_val = {job.is_write, job.reg_idx};
			3'd3: byte_val = job.value[31:24];
			3'd4: byte_val = job.value[23:16];
			3'd5: byte_val = job.value[15:8];
			3'd6: byte_val = job.value[7:0];
			default: byte_val = '0;
		endcase
	end

	always_comb begin
		if (job.is_reply) begin
			out_item.kind         = sudc_pkg::KIND_REPORT;
			out_item.tx_byte      = '0;
			out_item.last         = 1'b0;
			out_item.reply_status = job.status;
			out_item.read_data    = job.data;
		end else begin
			out_item.kind         = sudc_pkg::KIND_TX;
			out_item.tx_byte      = at_end ? crc_q : byte_val;
			out_item.last         = at_end;
			out_item.reply_status = sudc_pkg::ST_PENDING;
			out_item.read_data    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= '0;
		end else if (step && !job.is_reply) begin
			if (at_end) begin
				idx_q <= '0;
				crc_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				crc_q <= sudc_pkg::crc_fold(crc_q, byte_val);
			end
		end
	end

endmodule

[src/stepper_uart_datagram_codec_top.sv]
// host side of a single-wire register datagram link
// input queue port: push/full with in_item; op write, read, reply byte or none
// result queue port: empty/pop with out_item, oldest result shown while empty is low
// config channel: cfg_valid/cfg_ready/cfg_data sets the node address, always ready
// a write request yields 8 transmit items (sync, node, reg|0x80, value msb first, crc),
// a read request yields 4 (sync, node, reg, crc) and restarts reply collection,
// each reply byte yields one progress report, the eighth one carrying the verdict
// the front takes one item per cycle while the job queue has room; the back emits
// one result per cycle while a job waits and the result queue has room; an accepted
// item passes the job queue, then the result queue, before its first result shows
// when pop stays low the result queue fills, the back stalls, then the job queue
// fills and full rises; nothing is dropped
// reset clears the node address, the reply state and both queues
module stepper_uart_datagram_codec_top #(
	parameter int JOB_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sudc_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output sudc_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);

	logic                job_push;
	logic                job_pop;
	logic                job_empty;
	sudc_pkg::job_t      job_in;
	sudc_pkg::job_t      job_head;
	logic                out_push;
	logic                out_full;
	sudc_pkg::out_item_t out_next;

	assign cfg_ready = 1'b1;

	sudc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.push     (push),
		.in_item  (in_item),
		.job_full (full),
		.job_push (job_push),
		.job      (job_in)
	);

	sudc_fifo #(.DEPTH(JOB_DEPTH), .T(sudc_pkg::job_t)) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_data(job_in),
		.full   (full),
		.pop    (job_pop),
		.rd_data(job_head),
		.empty  (job_empty)
	);

	sudc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (job_head),
		.job_pop  (job_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_item (out_next)
	);

	sudc_fifo #(.DEPTH(OUT_DEPTH), .T(sudc_pkg::out_item_t)) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wr_data(out_next),
		.full   (out_full),
		.pop    (pop),
		.rd_data(out_item),
		.empty  (empty)
	);

endmodule

[src/sudc_checker.sv]
module sudc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input sudc_pkg::out_item_t out_item
);

	// progress reports carry no transmit byte and no last flag
	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.kind == sudc_pkg::KIND_REPORT) |->
			(out_item.tx_byte == 8'd0 && !out_item.last))
		else $error("report item carries transmit fields");

	// transmit items carry no reply verdict
	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.kind == sudc_pkg::KIND_TX) |->
			(out_item.reply_status == sudc_pkg::ST_PENDING && out_item.read_data == 32'd0))
		else $error("transmit item carries reply fields");

	// data only comes with a good verdict
	a_data_good: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.read_data != 32'd0) |->
			(out_item.reply_status == sudc_pkg::ST_GOOD))
		else $error("read data without good status");

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("result changed while stalled");

endmodule

bind stepper_uart_datagram_codec_top sudc_checker u_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import sudc_pkg::*;

	localparam logic [7:0] WRITE_FLAG = 8'h80;
	localparam int         IDLE_PCT   = 38;

	typedef enum int {REPLY_GOOD, REPLY_BAD_CRC, REPLY_BAD_HEADER, REPLY_BAD_BOTH} reply_fault_t;

	class codec_checker;
		out_item_t  due_results[$];
		logic [1:0]  node_addr = '0;
		logic [6:0]  asked_reg = '0;
		logic [2:0]  reply_pos = '0;
		logic [7:0]  reply_crc = '0;
		logic        hdr_bad   = 1'b0;
		logic [31:0] data_sr   = '0;
		int          failures  = 0;

		static function logic [7:0] fold_crc(logic [7:0] c, logic [7:0] b);
			for (int i = 0; i < 8; i++) begin
				c = {c[6:0], 1'b0} ^ ((c[7] ^ b[i]) ? CRC_POLY : 8'h00);
			end
			return c;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10) begin
				$display("%0t: %s", $realtime, msg);
			end
		endfunction

		function void set_node(logic [1:0] v);
			node_addr = v;
		endfunction

		function void clear_reply();
			reply_pos = '0;
			reply_crc = '0;
			hdr_bad   = 1'b0;
			data_sr   = '0;
		endfunction

		function out_item_t make_result(logic k, logic [7:0] tx, logic lst, logic [1:0] st,
				logic [31:0] d);
			out_item_t r;
			r.kind         = k;
			r.tx_byte      = tx;
			r.last         = lst;
			r.reply_status = st;
			r.read_data    = d;
			return r;
		endfunction

		function void note_item(in_item_t it);
			logic [7:0]  frame [7];
			logic [7:0]  crc;
			logic [1:0]  verdict;
			logic [31:0] payload;
			int          n;
			n = 0;
			case (it.operation)
				OP_WRITE: begin
					frame = '{SYNC_BYTE, {6'd0, node_addr}, WRITE_FLAG | {1'b0, it.register_index},
						it.write_value[31:24], it.write_value[23:16], it.write_value[15:8],
						it.write_value[7:0]};
					n = 7;
				end
				OP_READ: begin
					frame[0] = SYNC_BYTE;
					frame[1] = {6'd0, node_addr};
					frame[2] = {1'b0, it.register_index};
					asked_reg = it.register_index;
					clear_reply();
					n = 3;
				end
				OP_REPLY: begin
					if (reply_pos == REPLY_LAST) begin
						if (hdr_bad) begin
							verdict = ST_HEADER;
						end else if (reply_crc != it.reply_byte) begin
							verdict = ST_CRC;
						end else begin
							verdict = ST_GOOD;
						end
						payload = (verdict == ST_GOOD) ? data_sr : 32'd0;
						due_results.push_back(make_result(KIND_REPORT, 8'd0, 1'b0, verdict, payload));
						clear_reply();
					end else begin
						case (reply_pos)
							3'd0: if (it.reply_byte != SYNC_BYTE) hdr_bad = 1'b1;
							3'd1: if (it.reply_byte != MASTER_ADDR) hdr_bad = 1'b1;
							3'd2: if (it.reply_byte[6:0] != asked_reg) hdr_bad = 1'b1;
							default: data_sr = {data_sr[23:0], it.reply_byte};
						endcase
						reply_crc = fold_crc(reply_crc, it.reply_byte);
						reply_pos = reply_pos + 3'd1;
						due_results.push_back(make_result(KIND_REPORT, 8'd0, 1'b0, ST_PENDING, 32'd0));
					end
				end
				default: ;
			endcase
			if (n > 0) begin
				crc = '0;
				for (int i = 0; i < n; i++) begin
					due_results.push_back(make_result(KIND_TX, frame[i], 1'b0, ST_PENDING, 32'd0));
					crc = fold_crc(crc, frame[i]);
				end
				due_results.push_back(make_result(KIND_TX, crc, 1'b1, ST_PENDING, 32'd0));
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (due_results.size() == 0) begin
				flag($sformatf("unexpected result %h", got));
				return;
			end
			e = due_results.pop_front();
			if (got.kind !== e.kind)
				flag($sformatf("kind: expected %0d, got %0d", e.kind, got.kind));
			if (got.tx_byte !== e.tx_byte)
				flag($sformatf("tx_byte: expected %h, got %h", e.tx_byte, got.tx_byte));
			if (got.last !== e.last)
				flag($sformatf("last: expected %0d, got %0d", e.last, got.last));
			if (got.reply_status !== e.reply_status)
				flag($sformatf("reply_status: expected %0d, got %0d", e.reply_status,
					got.reply_status));
			if (got.read_data !== e.read_data)
				flag($sformatf("read_data: expected %h, got %h", e.read_data, got.read_data));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  in_item;
	logic      empty;
	logic      pop;
	out_item_t out_item;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_data;

	codec_checker chk;
	logic         steady = 1'b0;
	int           sent = 0;

	stepper_uart_datagram_codec_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic in_item_t mk(logic [1:0] op, logic [6:0] r, logic [31:0] v, logic [7:0] b);
		in_item_t it;
		it.operation      = op;
		it.register_index = r;
		it.write_value    = v;
		it.reply_byte     = b;
		return it;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(input in_item_t it);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		chk.note_item(it);
		if (it.operation != OP_NONE) begin
			sent++;
		end
	endtask

	task automatic write_node(input logic [1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		chk.set_node(v);
	endtask

	// wait for every due result, then some slack in case an ignored item is still in flight
	task automatic drain();
		push <= 1'b0;
		while (chk.due_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send_reply(input logic [6:0] r, input logic [31:0] d, input reply_fault_t fault,
			input logic echo_hi);
		logic [7:0] b [8];
		logic [7:0] c;
		int         pos;
		b[0] = SYNC_BYTE;
		b[1] = MASTER_ADDR;
		b[2] = {echo_hi, r};
		b[3] = d[31:24];
		b[4] = d[23:16];
		b[5] = d[15:8];
		b[6] = d[7:0];
		if (fault == REPLY_BAD_HEADER || fault == REPLY_BAD_BOTH) begin
			pos = $urandom_range(2);
			// echo compare only sees the low seven bits
			b[pos] = b[pos] ^ ((pos == 2) ? 8'($urandom_range(1, 127)) :
				8'($urandom_range(1, 255)));
		end
		c = '0;
		for (int i = 0; i < 7; i++) begin
			c = codec_checker::fold_crc(c, b[i]);
		end
		b[7] = (fault == REPLY_BAD_CRC || fault == REPLY_BAD_BOTH) ?
			c ^ 8'($urandom_range(1, 255)) : c;
		for (int i = 0; i < 8; i++) begin
			push_item(mk(OP_REPLY, 7'($urandom), $urandom, b[i]));
		end
	endtask

	task automatic run_traffic(input int upto);
		int           pick;
		int           n;
		int           m;
		logic [6:0]   r;
		reply_fault_t fault;
		while (sent < upto) begin
			pick = $urandom_range(99);
			r = 7'($urandom);
			if (pick < 40) begin
				// read followed by a full reply, mostly well formed
				push_item(mk(OP_READ, r, $urandom, 8'($urandom)));
				m = $urandom_range(99);
				fault = (m < 70) ? REPLY_GOOD : (m < 82) ? REPLY_BAD_CRC :
					(m < 94) ? REPLY_BAD_HEADER : REPLY_BAD_BOTH;
				send_reply(r, rand_word(), fault, 1'($urandom));
			end else if (pick < 65) begin
				push_item(mk(OP_WRITE, r, rand_word(), 8'($urandom)));
			end else if (pick < 78) begin
				push_item(mk(OP_READ, r, $urandom, 8'($urandom)));
			end else if (pick < 95) begin
				n = $urandom_range(1, 9);
				repeat (n) begin
					push_item(mk(OP_REPLY, 7'($urandom), $urandom,
						($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom)));
				end
			end else begin
				push_item(mk(OP_NONE, r, $urandom, 8'($urandom)));
			end
		end
	endtask

	// result side
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				chk.check_result(out_item);
			end
			pop <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		in_item   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		chk = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_node(2'd2);
		// reply before any read request is judged against register 0
		send_reply(7'd0, 32'h8000_0001, REPLY_GOOD, 1'b1);
		push_item(mk(OP_WRITE, 7'd0, 32'd0, 8'd0));
		push_item(mk(OP_WRITE, 7'd127, 32'hFFFF_FFFF, 8'hFF));
		push_item(mk(OP_NONE, 7'd127, 32'hFFFF_FFFF, 8'hFF));
		push_item(mk(OP_READ, 7'd127, 32'd0, 8'd0));
		// header and crc both wrong: header mismatch wins
		send_reply(7'd127, 32'h1234_5678, REPLY_BAD_BOTH, 1'b0);
		drain();

		write_node(2'd0);
		run_traffic(140);
		drain();
		write_node(2'd3);
		steady = 1'b1;
		run_traffic(260);
		drain();
		steady = 1'b0;
		write_node(2'd1);
		run_traffic(380);
		drain();
		write_node(2'($urandom));
		run_traffic(500);
		drain();

		if (chk.due_results.size() != 0) begin
			chk.flag($sformatf("%0d results never arrived", chk.due_results.size()));
		end
		if (chk.failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
